### rtl/jfps_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi five-point stencil package
// Cell and sum types, saturation limits and the reciprocal used to scale
// the five-cell sum by one fifth.
// ----------------------------------------------------------------------------
package jfps_pkg;

    localparam int CELL_W = 32;
    localparam int SIZE_W = 10;
    // Five signed cells need three guard bits.
    localparam int SUM_W  = CELL_W + 3;

    typedef logic signed [CELL_W-1:0]   cell_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic        [2*CELL_W-1:0] prod_t;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd1022;

    localparam cell_t CELL_MAX = 32'sh7FFF_FFFF;
    localparam cell_t CELL_MIN = 32'sh8000_0000;
    localparam sum_t  SUM_MAX  = sum_t'(CELL_MAX);
    localparam sum_t  SUM_MIN  = sum_t'(CELL_MIN);

    // floor(x / 5) == (x * RECIP_5) >> RECIP_SHIFT for every 32-bit x.
    localparam logic [CELL_W-1:0] RECIP_5     = 32'hCCCC_CCCD;
    localparam int                RECIP_SHIFT = 34;

    // Added before the divide so that the quotient rounds to nearest.
    localparam logic [CELL_W-1:0] ROUND_BIAS = 32'd2;

endpackage

### rtl/jacobi_five_point_stencil.sv
// ----------------------------------------------------------------------------
// Jacobi five-point stencil
// Streams a square grid in raster order and returns the averaged interior.
// ----------------------------------------------------------------------------
// Cells of an (interior_size+2)-wide square grid, border included, enter on
// the cell channel (cell_valid / cell_stall / cell_value), one beat per cell
// in raster order. For every interior cell, once the row below has reached
// its column, one beat leaves on the result channel (result_valid /
// result_stall / new_value, last_of_grid): one fifth of the saturated sum of
// the cell and its four neighbours, rounded to nearest, in interior raster
// order. last_of_grid marks the final interior cell of the grid.
// Throughput is one cell per clock unless the result channel stalls.
// A result passes through the adder, saturation, reciprocal multiplier and
// output register stages in turn. The rate is held by two row memories,
// read one column ahead so their data is ready when a cell lands.
// When result_stall is high the pipeline fills and then cell_stall rises;
// nothing is dropped. Reset clears the counters and sets interior_size to
// 1022; writing interior_size restarts the sweep at the top-left corner.
// ----------------------------------------------------------------------------
module jacobi_five_point_stencil #(
    parameter int MAX_GRID_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          interior_size_wr_en,
    input  logic [jfps_pkg::SIZE_W-1:0]   interior_size_wr_data,

    input  logic                          cell_valid,
    output logic                          cell_stall,
    input  jfps_pkg::cell_t               cell_value,

    output logic                          result_valid,
    input  logic                          result_stall,
    output jfps_pkg::cell_t               new_value,
    output logic                          last_of_grid
);

    localparam int AW = $clog2(MAX_GRID_WIDTH);
    localparam int LW = ((AW > jfps_pkg::SIZE_W) ? AW : jfps_pkg::SIZE_W) + 1;

    // Configuration and position
    logic [jfps_pkg::SIZE_W-1:0] size_reg;
    logic [LW-1:0]               size_ext;
    logic [LW-1:0]               size_eff;
    logic [AW-1:0]               last_col;
    logic [AW-1:0]               col_reg;
    logic [AW-1:0]               col_next;
    logic [AW-1:0]               row_reg;
    logic [AW-1:0]               row_next;
    logic [AW-1:0]               right_addr;

    logic                        accept;
    logic                        interior;
    logic                        is_last;

    // Row store outputs
    jfps_pkg::cell_t             mid_reg;
    jfps_pkg::cell_t             right_q;
    jfps_pkg::cell_t             up_q;
    jfps_pkg::cell_t             left_reg;

    // Pipeline
    logic                        ready_s1;
    logic                        ready_s2;
    logic                        ready_s3;
    logic                        ready_out;

    logic                        s1_valid_reg;
    jfps_pkg::sum_t              s1_sum_reg;
    jfps_pkg::sum_t              s1_sum_next;
    logic                        s1_last_reg;

    logic                        s2_valid_reg;
    logic [jfps_pkg::CELL_W-1:0] s2_x_reg;
    logic [jfps_pkg::CELL_W-1:0] s2_x_next;
    logic                        s2_neg_reg;
    logic                        s2_last_reg;
    jfps_pkg::cell_t             sat_val;
    logic [jfps_pkg::CELL_W-1:0] sat_mag;

    logic                        s3_valid_reg;
    jfps_pkg::prod_t             s3_prod_reg;
    logic                        s3_neg_reg;
    logic                        s3_last_reg;
    jfps_pkg::prod_t             quot_wide;
    logic [jfps_pkg::CELL_W-1:0] quot;

    logic                        out_valid_reg;
    jfps_pkg::cell_t             out_value_reg;
    jfps_pkg::cell_t             out_value_next;
    logic                        out_last_reg;

    // ------------------------------------------------------------------------
    // Grid geometry
    // ------------------------------------------------------------------------
    always_comb
    begin
        size_ext = LW'(size_reg);
        if (size_ext > LW'(MAX_GRID_WIDTH - 2))
        begin
            size_eff = LW'(MAX_GRID_WIDTH - 2);
        end
        else
        begin
            size_eff = size_ext;
        end
        last_col = AW'(size_eff + 1'b1);
    end

    assign accept   = cell_valid && !cell_stall;
    assign interior = (row_reg >= AW'(2)) && (col_reg != '0) && (col_reg != last_col);
    assign is_last  = (row_reg == last_col) && (col_reg == last_col - 1'b1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (interior_size_wr_en)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == last_col)
            begin
                col_next = '0;
                if (row_reg == last_col)
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= jfps_pkg::SIZE_RESET;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            if (interior_size_wr_en)
            begin
                size_reg <= interior_size_wr_data;
            end
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------------
    // Row stores. Reads follow the position of the next cell, so the data
    // sits ready when that cell arrives. The middle store is read one column
    // further right; the cell it returns becomes the center for the next
    // column, and at the end of a row the read wraps to column zero. Unless
    // the size is zero or is written, no write hits an address read next.
    // ------------------------------------------------------------------------
    assign right_addr = (col_next == last_col) ? '0 : col_next + 1'b1;

    jfps_ram #(
        .WIDTH (jfps_pkg::CELL_W),
        .DEPTH (MAX_GRID_WIDTH)
    ) u_upper_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (mid_reg),
        .rd_addr (col_next),
        .rd_data (up_q)
    );

    jfps_ram #(
        .WIDTH (jfps_pkg::CELL_W),
        .DEPTH (MAX_GRID_WIDTH)
    ) u_middle_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (col_reg),
        .wr_data (cell_value),
        .rd_addr (right_addr),
        .rd_data (right_q)
    );

    // ------------------------------------------------------------------------
    // Arithmetic pipeline
    // ------------------------------------------------------------------------
    assign ready_out  = !out_valid_reg || !result_stall;
    assign ready_s3   = !s3_valid_reg || ready_out;
    assign ready_s2   = !s2_valid_reg || ready_s3;
    assign ready_s1   = !s1_valid_reg || ready_s2;
    assign cell_stall = !ready_s1;

    assign s1_sum_next = jfps_pkg::sum_t'(mid_reg) + jfps_pkg::sum_t'(left_reg)
                       + jfps_pkg::sum_t'(right_q) + jfps_pkg::sum_t'(up_q)
                       + jfps_pkg::sum_t'(cell_value);

    always_comb
    begin
        if (s1_sum_reg > jfps_pkg::SUM_MAX)
        begin
            sat_val = jfps_pkg::CELL_MAX;
        end
        else if (s1_sum_reg < jfps_pkg::SUM_MIN)
        begin
            sat_val = jfps_pkg::CELL_MIN;
        end
        else
        begin
            sat_val = s1_sum_reg[jfps_pkg::CELL_W-1:0];
        end
        // The magnitude of the most negative value still fits unsigned.
        if (sat_val[jfps_pkg::CELL_W-1])
        begin
            sat_mag = ~sat_val + 1'b1;
        end
        else
        begin
            sat_mag = sat_val;
        end
        s2_x_next = sat_mag + jfps_pkg::ROUND_BIAS;
    end

    always_comb
    begin
        quot_wide = s3_prod_reg >> jfps_pkg::RECIP_SHIFT;
        quot      = quot_wide[jfps_pkg::CELL_W-1:0];
        if (s3_neg_reg)
        begin
            out_value_next = ~quot + 1'b1;
        end
        else
        begin
            out_value_next = quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_s1)
            begin
                s1_valid_reg <= accept && interior;
            end
            if (ready_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready_s3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ready_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg <= mid_reg;
            mid_reg  <= right_q;
        end
        if (ready_s1)
        begin
            s1_sum_reg  <= s1_sum_next;
            s1_last_reg <= is_last;
        end
        if (ready_s2)
        begin
            s2_x_reg    <= s2_x_next;
            s2_neg_reg  <= sat_val[jfps_pkg::CELL_W-1];
            s2_last_reg <= s1_last_reg;
        end
        if (ready_s3)
        begin
            s3_prod_reg <= jfps_pkg::prod_t'(s2_x_reg) * jfps_pkg::prod_t'(jfps_pkg::RECIP_5);
            s3_neg_reg  <= s2_neg_reg;
            s3_last_reg <= s2_last_reg;
        end
        if (ready_out)
        begin
            out_value_reg <= out_value_next;
            out_last_reg  <= s3_last_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign new_value    = out_value_reg;
    assign last_of_grid = out_last_reg;

`ifndef SYNTHESIS
    // The raster position never leaves the grid.
    a_position_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= last_col) && (row_reg <= last_col))
        else $error("raster position outside the grid");

    // Input back-pressure only when every stage holds a result.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cell_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg
                        && out_valid_reg && result_stall))
        else $error("cell stalled with room in the pipeline");

    // An accepted interior cell enters the first stage.
    a_interior_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && interior) |=> s1_valid_reg)
        else $error("interior cell lost at pipeline entry");
`endif

endmodule

### rtl/jfps_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module jfps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
